[hw/rtl/bbt_pkg.sv]
package bbt_pkg;

  // Field widths
  localparam int FuncW  = 5;
  localparam int BoardW = 64;
  localparam int AmtW   = 6;
  localparam int CountW = 7;

  typedef logic [FuncW-1:0]  func_t;
  typedef logic [BoardW-1:0] board_t;
  typedef logic [AmtW-1:0]   amt_t;
  typedef logic [CountW-1:0] count_t;

  // One input item as held in the input register
  typedef struct packed {
    func_t  func;
    board_t board;
    board_t other_board;
    amt_t   amount;
  } item_t;

  // Opcodes
  localparam func_t FN_NOT      = 5'd0;
  localparam func_t FN_AND      = 5'd1;
  localparam func_t FN_OR       = 5'd2;
  localparam func_t FN_XOR      = 5'd3;
  localparam func_t FN_SHL      = 5'd4;
  localparam func_t FN_SHR      = 5'd5;
  localparam func_t FN_SUB      = 5'd6;
  localparam func_t FN_ROTL     = 5'd7;
  localparam func_t FN_ROTR     = 5'd8;
  localparam func_t FN_FLIPV    = 5'd9;
  localparam func_t FN_FLIPDIAG = 5'd10;
  localparam func_t FN_ROT90CW  = 5'd11;
  localparam func_t FN_ROT90ACW = 5'd12;
  localparam func_t FN_P45CW    = 5'd13;
  localparam func_t FN_P45ACW   = 5'd14;
  localparam func_t FN_UNP45CW  = 5'd15;
  localparam func_t FN_UNP45ACW = 5'd16;
  localparam func_t FN_POPCNT   = 5'd17;
  localparam func_t FN_LOWIDX   = 5'd18;
  localparam func_t FN_SQBIT    = 5'd19;

  // Pseudo-rotation masks
  localparam board_t MASK_CW1  = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam board_t MASK_CW2  = 64'hCCCC_CCCC_CCCC_CCCC;
  localparam board_t MASK_CW4  = 64'hF0F0_F0F0_F0F0_F0F0;
  localparam board_t MASK_ACW1 = 64'h5555_5555_5555_5555;
  localparam board_t MASK_ACW2 = 64'h3333_3333_3333_3333;
  localparam board_t MASK_ACW4 = 64'h0F0F_0F0F_0F0F_0F0F;

  // Index returned for an empty board
  localparam count_t EMPTY_IDX = 7'd64;

endpackage

[hw/rtl/bbt_in_if.sv]
interface bbt_in_if import bbt_pkg::*; ();
  logic   valid;
  logic   ready;
  func_t  func;
  board_t board;
  board_t other_board;
  amt_t   amount;

  modport source (output valid, func, board, other_board, amount, input ready);
  modport sink   (input valid, func, board, other_board, amount, output ready);
endinterface

[hw/rtl/bbt_out_if.sv]
interface bbt_out_if import bbt_pkg::*; ();
  logic   valid;
  logic   ready;
  board_t result;

  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

[hw/rtl/bitboard_transform_alu.sv]
// Channel  Dir  Payload                             Handshake
// in_ch    in   func, board, other_board, amount    valid/ready
// out_ch   out  result                              valid/ready
//
// One item per cycle sustained while out_ch is not stalled; a result passes through the input
// register and then the result register, with the operation logic in between.
// Reset (synchronous, active low) empties both registers.
// While the output is stalled one more item is taken into the input register,
// then in_ch.ready drops until the result register drains.
module bitboard_transform_alu import bbt_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  bbt_in_if.sink    in_ch,
  bbt_out_if.source out_ch
);

  item_t  item_r;
  item_t  item_nxt;
  logic   item_vld_r;
  board_t result_r;
  board_t result_nxt;
  logic   out_vld_r;
  logic   adv;

  board_t arith_res;
  board_t perm_res;
  board_t count_res;

  // Handshake control
  assign adv         = item_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !item_vld_r || adv;

  assign item_nxt = '{func: in_ch.func, board: in_ch.board,
                      other_board: in_ch.other_board, amount: in_ch.amount};

  // Operation units, each zero outside its own opcodes
  bbt_arith   u_arith   (.item(item_r), .result(arith_res));
  bbt_permute u_permute (.item(item_r), .result(perm_res));
  bbt_count   u_count   (.item(item_r), .result(count_res));

  assign result_nxt = arith_res | perm_res | count_res;

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (in_ch.ready) item_vld_r <= in_ch.valid;
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) item_r <= item_nxt;
    if (adv) result_r <= result_nxt;
  end

  assign out_ch.valid  = out_vld_r;
  assign out_ch.result = result_r;

endmodule

[hw/rtl/bbt_arith.sv]
module bbt_arith import bbt_pkg::*; (
  input  item_t  item,
  output board_t result
);

  logic [2*BoardW-1:0] dbl;
  logic [2*BoardW-1:0] dbl_l;
  logic [2*BoardW-1:0] dbl_r;

  // Rotates as shifts of the doubled word; amount zero falls out unchanged
  assign dbl   = {item.board, item.board};
  assign dbl_l = dbl << item.amount;
  assign dbl_r = dbl >> item.amount;

  // Logic, shift, subtract, rotate and square bit group; zero for other opcodes
  always_comb begin
    case (item.func)
      FN_NOT:   result = ~item.board;
      FN_AND:   result = item.board & item.other_board;
      FN_OR:    result = item.board | item.other_board;
      FN_XOR:   result = item.board ^ item.other_board;
      FN_SHL:   result = item.board << item.amount;
      FN_SHR:   result = item.board >> item.amount;
      FN_SUB:   result = item.board - item.other_board;
      FN_ROTL:  result = dbl_l[2*BoardW-1:BoardW];
      FN_ROTR:  result = dbl_r[BoardW-1:0];
      FN_SQBIT: result = board_t'(1) << item.amount;
      default:  result = '0;
    endcase
  end

endmodule

[hw/rtl/bbt_permute.sv]
module bbt_permute import bbt_pkg::*; (
  input  item_t  item,
  output board_t result
);

  // Mirror ranks: square (r,f) -> (7-r,f)
  function automatic board_t flip_v(input board_t v);
    board_t o;
    for (int r = 0; r < 8; r++) begin
      o[8*(7-r) +: 8] = v[8*r +: 8];
    end
    return o;
  endfunction

  // Swap rank and file about the a1-h8 diagonal
  function automatic board_t flip_diag(input board_t v);
    board_t o;
    for (int r = 0; r < 8; r++) begin
      for (int f = 0; f < 8; f++) begin
        o[8*r+f] = v[8*f+r];
      end
    end
    return o;
  endfunction

  // Fixed rotates by a constant amount
  function automatic board_t rotl_k(input board_t v, input int k);
    return (v << k) | (v >> (BoardW - k));
  endfunction

  function automatic board_t rotr_k(input board_t v, input int k);
    return (v >> k) | (v << (BoardW - k));
  endfunction

  // Three masked merge steps of the pseudo 45 degree rotation
  function automatic board_t p45(input board_t v, input board_t m1, input board_t m2,
                                 input board_t m4, input logic undo);
    board_t a;
    board_t b;
    board_t c;
    a = (m1 & (undo ? rotl_k(v, 8)  : rotr_k(v, 8)))  | (~m1 & v);
    b = (m2 & (undo ? rotl_k(a, 16) : rotr_k(a, 16))) | (~m2 & a);
    c = (m4 & (undo ? rotl_k(b, 32) : rotr_k(b, 32))) | (~m4 & b);
    return c;
  endfunction

  // Board geometry group; zero for other opcodes
  always_comb begin
    case (item.func)
      FN_FLIPV:    result = flip_v(item.board);
      FN_FLIPDIAG: result = flip_diag(item.board);
      FN_ROT90CW:  result = flip_v(flip_diag(item.board));
      FN_ROT90ACW: result = flip_diag(flip_v(item.board));
      FN_P45CW:    result = p45(item.board, MASK_CW1, MASK_CW2, MASK_CW4, 1'b0);
      FN_P45ACW:   result = p45(item.board, MASK_ACW1, MASK_ACW2, MASK_ACW4, 1'b0);
      FN_UNP45CW:  result = p45(item.board, MASK_CW1, MASK_CW2, MASK_CW4, 1'b1);
      FN_UNP45ACW: result = p45(item.board, MASK_ACW1, MASK_ACW2, MASK_ACW4, 1'b1);
      default:     result = '0;
    endcase
  end

endmodule

[hw/rtl/bbt_count.sv]
module bbt_count import bbt_pkg::*; (
  input  item_t  item,
  output board_t result
);

  logic [1:0] s1 [32];
  logic [2:0] s2 [16];
  logic [3:0] s3 [8];
  logic [4:0] s4 [4];
  logic [5:0] s5 [2];
  count_t     pop;

  logic [7:0] byte_nz;
  logic [2:0] byte_sel;
  logic [7:0] low_byte;
  logic [2:0] bit_sel;
  count_t     low_idx;

  // Population count as an adder tree
  always_comb begin
    for (int i = 0; i < 32; i++) s1[i] = {1'b0, item.board[2*i]} + {1'b0, item.board[2*i+1]};
    for (int i = 0; i < 16; i++) s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
    for (int i = 0; i < 8; i++)  s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    for (int i = 0; i < 4; i++)  s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
    for (int i = 0; i < 2; i++)  s5[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
    pop = {1'b0, s5[0]} + {1'b0, s5[1]};
  end

  // Lowest set bit: first nonzero byte, then first set bit inside it
  always_comb begin
    byte_sel = '0;
    bit_sel  = '0;
    for (int i = 0; i < 8; i++) byte_nz[i] = |item.board[8*i +: 8];
    for (int i = 7; i >= 0; i--) begin
      if (byte_nz[i]) byte_sel = 3'(i);
    end
    low_byte = item.board[8*byte_sel +: 8];
    for (int i = 7; i >= 0; i--) begin
      if (low_byte[i]) bit_sel = 3'(i);
    end
    low_idx = (|byte_nz) ? {1'b0, byte_sel, bit_sel} : EMPTY_IDX;
  end

  // Counting group; zero for other opcodes
  always_comb begin
    case (item.func)
      FN_POPCNT: result = board_t'(pop);
      FN_LOWIDX: result = board_t'(low_idx);
      default:   result = '0;
    endcase
  end

endmodule
